>>> rtl/core/mdgs_pkg.sv
`default_nettype none

package mdgs_pkg;

  // Default sample width of the audio path.
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_FRAC_BITS  = 2'd0,
    CFG_DC_RATE_SHIFT = 2'd1,
    CFG_GAIN          = 2'd2
  } cfg_idx_t;

  // Request codes carried in req_type.
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Live configuration shared by the tracker and gain stages.
  typedef struct packed {
    logic [3:0] frac_bits;
    logic [3:0] rate_shift;
    logic [6:0] gain;
  } mdgs_cfg_t;

  // Register values after reset.
  localparam logic [3:0] FRAC_BITS_RST  = 4'd8;
  localparam logic [3:0] RATE_SHIFT_RST = 4'd6;
  localparam logic [6:0] GAIN_RST       = 7'd8;

endpackage

`default_nettype wire

>>> rtl/core/mdgs_sample_if.sv
`default_nettype none

interface mdgs_sample_if #(
  parameter int SAMPLE_WIDTH = mdgs_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink (input valid, input req_type, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mdgs_result_if.sv
`default_nettype none

interface mdgs_result_if #(
  parameter int SAMPLE_WIDTH = mdgs_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] clean_sample;
  logic [31:0]                    abs_sum;
  logic [SAMPLE_WIDTH-1:0]        peak_level;
  logic [31:0]                    sample_count;

  modport source (output valid, output clean_sample, output abs_sum, output peak_level,
                  output sample_count, input ready);
  modport sink (input valid, input clean_sample, input abs_sum, input peak_level,
                input sample_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mdgs_cfg_if.sv
`default_nettype none

interface mdgs_cfg_if;
  import mdgs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mdgs_tracker.sv
`default_nettype none

module mdgs_tracker #(
  parameter int SAMPLE_WIDTH = mdgs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  mdgs_pkg::mdgs_cfg_t                   cfg,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_req,
  input  wire signed [SAMPLE_WIDTH-1:0]         in_sample,
  output logic                                  s1_valid,
  input  wire                                   s1_ready,
  output logic                                  s1_req,
  output logic signed [SAMPLE_WIDTH-1:0]        s1_x,
  output logic signed [SAMPLE_WIDTH+15:0]       s1_dc
);
  import mdgs_pkg::*;

  localparam int DC_W = SAMPLE_WIDTH + 16;

  logic                    s1_valid_r;
  logic                    s1_req_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r;
  logic signed [DC_W-1:0]  s1_dc_r;
  logic signed [DC_W-1:0]  dc_level_r;
  logic                    primed_r;

  logic                    accept;
  logic signed [DC_W-1:0]  scaled;
  logic signed [DC_W-1:0]  base;
  logic signed [DC_W:0]    diff;
  logic signed [DC_W:0]    step;
  logic signed [DC_W-1:0]  dc_nxt;

  // The stage takes a beat when it is empty or its content moves on.
  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  // One tracker update: prime on the first sample, then move toward the input.
  always_comb begin
    scaled = DC_W'(in_sample) <<< cfg.frac_bits;
    base   = primed_r ? dc_level_r : scaled;
    diff   = {scaled[DC_W-1], scaled} - {base[DC_W-1], base};
    step   = diff >>> cfg.rate_shift;
    dc_nxt = base + step[DC_W-1:0];
  end

  // Tracker state and the stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      dc_level_r <= '0;
      primed_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (accept) begin
        if (in_req == REQ_RESTART) begin
          dc_level_r <= '0;
          primed_r   <= 1'b0;
        end else begin
          dc_level_r <= dc_nxt;
          primed_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_req;
      s1_x_r   <= in_sample;
      s1_dc_r  <= dc_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_req   = s1_req_r;
  assign s1_x     = s1_x_r;
  assign s1_dc    = s1_dc_r;

endmodule

`default_nettype wire

>>> rtl/core/mdgs_gain.sv
`default_nettype none

module mdgs_gain #(
  parameter int SAMPLE_WIDTH = mdgs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  mdgs_pkg::mdgs_cfg_t                 cfg,
  input  wire                                 s1_valid,
  output logic                                s1_ready,
  input  wire                                 s1_req,
  input  wire signed [SAMPLE_WIDTH-1:0]       s1_x,
  input  wire signed [SAMPLE_WIDTH+15:0]      s1_dc,
  output logic                                s2_valid,
  input  wire                                 s2_ready,
  output logic                                s2_req,
  output logic signed [SAMPLE_WIDTH+8:0]      s2_prod
);
  import mdgs_pkg::*;

  localparam int DC_W   = SAMPLE_WIDTH + 16;
  localparam int PROD_W = SAMPLE_WIDTH + 9;
  localparam logic signed [SAMPLE_WIDTH:0] AC_MAX = {1'b0, {SAMPLE_WIDTH{1'b1}}};
  localparam logic signed [SAMPLE_WIDTH:0] AC_MIN = {1'b1, {SAMPLE_WIDTH{1'b0}}};

  logic                           s2_valid_r;
  logic                           s2_req_r;
  logic signed [PROD_W-1:0]       s2_prod_r;

  logic                           accept;
  logic signed [DC_W-1:0]         est_full;
  logic signed [DC_W:0]           ac_wide;
  logic [DC_W-SAMPLE_WIDTH:0]     ac_top;
  logic signed [SAMPLE_WIDTH:0]   ac_raw;
  logic signed [PROD_W-1:0]       ac_ext;
  logic signed [PROD_W-1:0]       gain_ext;
  logic signed [PROD_W-1:0]       prod;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign accept   = s1_valid && s1_ready;

  // Remove the integer part of the tracked offset and apply the gain. After a
  // fraction-bit change on a live tracker the offset can lie far outside the
  // sample range; such differences are clamped first, since any nonzero gain
  // saturates them and a zero gain clears them.
  always_comb begin
    est_full = s1_dc >>> cfg.frac_bits;
    ac_wide  = {{(DC_W+1-SAMPLE_WIDTH){s1_x[SAMPLE_WIDTH-1]}}, s1_x} -
               {est_full[DC_W-1], est_full};
    ac_top   = ac_wide[DC_W:SAMPLE_WIDTH];
    if ((ac_top == '0) || (ac_top == '1)) begin
      ac_raw = ac_wide[SAMPLE_WIDTH:0];
    end else if (ac_wide[DC_W]) begin
      ac_raw = AC_MIN;
    end else begin
      ac_raw = AC_MAX;
    end
    ac_ext   = PROD_W'(ac_raw);
    gain_ext = PROD_W'($signed({1'b0, cfg.gain}));
    prod     = ac_ext * gain_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_req_r  <= s1_req;
      s2_prod_r <= prod;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_req   = s2_req_r;
  assign s2_prod  = s2_prod_r;

endmodule

`default_nettype wire

>>> rtl/core/mdgs_stats.sv
`default_nettype none

module mdgs_stats #(
  parameter int SAMPLE_WIDTH = mdgs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 s2_valid,
  output logic                                s2_ready,
  input  wire                                 s2_req,
  input  wire signed [SAMPLE_WIDTH+8:0]       s2_prod,
  output logic                                res_valid,
  input  wire                                 res_ready,
  output logic                                res_restart,
  output logic signed [SAMPLE_WIDTH-1:0]      res_clean,
  output logic [31:0]                         res_abs_sum,
  output logic [SAMPLE_WIDTH-1:0]             res_peak,
  output logic [31:0]                         res_count
);
  import mdgs_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + 9;
  localparam int TOP_W  = PROD_W - SAMPLE_WIDTH + 1;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                           res_valid_r;
  logic                           res_restart_r;
  logic signed [SAMPLE_WIDTH-1:0] clean_r;
  logic [31:0]                    abs_total_r;
  logic [SAMPLE_WIDTH-1:0]        peak_mag_r;
  logic [31:0]                    count_total_r;

  logic                           accept;
  logic [TOP_W-1:0]               top_bits;
  logic                           in_range;
  logic signed [SAMPLE_WIDTH-1:0] ac;
  logic [SAMPLE_WIDTH-1:0]        mag;

  // The output register frees up when its beat is taken.
  assign s2_ready = !res_valid_r || res_ready;
  assign accept   = s2_valid && s2_ready;

  // Saturate to the sample range and take the magnitude.
  always_comb begin
    top_bits = s2_prod[PROD_W-1:SAMPLE_WIDTH-1];
    in_range = (top_bits == '0) || (top_bits == '1);
    if (in_range) begin
      ac = s2_prod[SAMPLE_WIDTH-1:0];
    end else if (s2_prod[PROD_W-1]) begin
      ac = SAT_MIN;
    end else begin
      ac = SAT_MAX;
    end
    mag = ac[SAMPLE_WIDTH-1] ? (~ac + 1'b1) : ac;
  end

  // Statistics live in the output register itself.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r   <= 1'b0;
      res_restart_r <= 1'b0;
      clean_r       <= '0;
      abs_total_r   <= '0;
      peak_mag_r    <= '0;
      count_total_r <= '0;
    end else begin
      if (s2_ready) begin
        res_valid_r <= s2_valid;
      end
      if (accept) begin
        res_restart_r <= (s2_req == REQ_RESTART);
        if (s2_req == REQ_RESTART) begin
          clean_r       <= '0;
          abs_total_r   <= '0;
          peak_mag_r    <= '0;
          count_total_r <= '0;
        end else begin
          clean_r       <= ac;
          abs_total_r   <= abs_total_r + 32'(mag);
          count_total_r <= count_total_r + 32'd1;
          if (mag > peak_mag_r) begin
            peak_mag_r <= mag;
          end
        end
      end
    end
  end

  assign res_valid   = res_valid_r;
  assign res_restart = res_restart_r;
  assign res_clean   = clean_r;
  assign res_abs_sum = abs_total_r;
  assign res_peak    = peak_mag_r;
  assign res_count   = count_total_r;

endmodule

`default_nettype wire

>>> rtl/core/mic_dc_block_gain_stats.sv
// Microphone DC blocker with gain and level statistics. Each beat on in_ch is
// either an audio sample or a restart; every beat yields exactly one result on
// out_ch. A one-pole fixed-point tracker removes the DC offset, the difference
// is multiplied by the integer gain and saturated to the sample range, and the
// output carries the running absolute sum, the peak magnitude and the sample
// count. A restart clears the tracker and the statistics and returns zeros.
// The block takes one beat per clock cycle while out_ch is ready; the result
// passes three registers (tracker, gain, output) before it is valid on out_ch.
// While out_ch is held off the three stages fill and in_ch stalls.
// The tracker recurrence closes within the first stage, and the statistics
// recurrence within the output register. Registers are written on cfg_ch,
// which is always ready; the user must write them only while no beat is in
// flight, since the block itself does not enforce this.

`default_nettype none

module mic_dc_block_gain_stats #(
  parameter int SAMPLE_WIDTH = mdgs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  mdgs_cfg_if.sink    cfg_ch,
  mdgs_sample_if.sink in_ch,
  mdgs_result_if.source out_ch
);
  import mdgs_pkg::*;

  localparam int DC_W   = SAMPLE_WIDTH + 16;
  localparam int PROD_W = SAMPLE_WIDTH + 9;

  mdgs_cfg_t                      cfg_r;

  logic                           s1_valid;
  logic                           s1_ready;
  logic                           s1_req;
  logic signed [SAMPLE_WIDTH-1:0] s1_x;
  logic signed [DC_W-1:0]         s1_dc;

  logic                           s2_valid;
  logic                           s2_ready;
  logic                           s2_req;
  logic signed [PROD_W-1:0]       s2_prod;

  logic                           res_restart;

  // Configuration registers; writes beyond the register list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frac_bits  <= FRAC_BITS_RST;
      cfg_r.rate_shift <= RATE_SHIFT_RST;
      cfg_r.gain       <= GAIN_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_DC_FRAC_BITS:  cfg_r.frac_bits  <= cfg_ch.data[3:0];
        CFG_DC_RATE_SHIFT: cfg_r.rate_shift <= cfg_ch.data[3:0];
        CFG_GAIN:          cfg_r.gain       <= cfg_ch.data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: DC tracker.
  mdgs_tracker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (in_ch.req_type),
    .in_sample (in_ch.sample),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_req    (s1_req),
    .s1_x      (s1_x),
    .s1_dc     (s1_dc)
  );

  // Stage two: offset removal and gain.
  mdgs_gain #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_req   (s1_req),
    .s1_x     (s1_x),
    .s1_dc    (s1_dc),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_req   (s2_req),
    .s2_prod  (s2_prod)
  );

  // Stage three: saturation, statistics and output register.
  mdgs_stats #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2_ready    (s2_ready),
    .s2_req      (s2_req),
    .s2_prod     (s2_prod),
    .res_valid   (out_ch.valid),
    .res_ready   (out_ch.ready),
    .res_restart (res_restart),
    .res_clean   (out_ch.clean_sample),
    .res_abs_sum (out_ch.abs_sum),
    .res_peak    (out_ch.peak_level),
    .res_count   (out_ch.sample_count)
  );

  // A restart result shows cleared statistics and a zero sample.
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && res_restart) |->
      (out_ch.clean_sample == '0 && out_ch.abs_sum == '0 &&
       out_ch.peak_level == '0 && out_ch.sample_count == '0))
    else $error("restart result carries nonzero fields");

  // The peak magnitude never exceeds the magnitude of the most negative sample.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.peak_level <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
    else $error("peak level above full scale");

  // The input side never stalls while the first stage is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ch.ready)
    else $error("input stalled with empty tracker stage");

endmodule

`default_nettype wire

>>> tb/mic_dc_block_gain_stats_test.sv
`timescale 1ns / 1ps

module mic_dc_block_gain_stats_test;
  import mdgs_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 12;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_AT_BEAT = 400;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam longint unsigned CYCLE_LIMIT = 200000;
  localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // One result beat as it appears on the output channel.
  typedef struct packed {
    logic signed [SW-1:0] clean;
    logic [31:0]          abs_sum;
    logic [SW-1:0]        peak;
    logic [31:0]          count;
  } clean_beat_t;

  typedef enum logic {ROW_ITEM, ROW_REGS} row_kind_t;

  // One line of the directed table: either a beat to send or a register set.
  typedef struct {
    row_kind_t     kind;
    logic          req;
    logic [SW-1:0] smp;
    logic [3:0]    frac;
    logic [3:0]    rate;
    logic [6:0]    gain;
    bit            known;
    clean_beat_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit calm = 1'b0;
  int unsigned beats_seen = 0;
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;
  clean_beat_t clean_queue[$];
  dir_row_t directed[$];

  // Shadow copy of the filter state and the live register values.
  longint      tracker_level = 0;
  bit          tracker_primed = 1'b0;
  logic [31:0] abs_running = '0;
  logic [31:0] count_running = '0;
  longint      peak_running = 0;
  logic [3:0]  cur_frac = FRAC_BITS_RST;
  logic [3:0]  cur_rate = RATE_SHIFT_RST;
  logic [6:0]  cur_gain = GAIN_RST;

  mdgs_sample_if #(.SAMPLE_WIDTH(SW)) in_if ();
  mdgs_result_if #(.SAMPLE_WIDTH(SW)) out_if ();
  mdgs_cfg_if cfg_if ();

  mic_dc_block_gain_stats #(.SAMPLE_WIDTH(SW)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if.sink),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // Advance the shadow filter by one input beat and return the result it yields.
  function automatic clean_beat_t dc_block_step(input logic req, input logic signed [SW-1:0] smp);
    longint x, scaled, ac, mag;
    clean_beat_t beat;
    if (req == REQ_RESTART) begin
      tracker_level = 0;
      tracker_primed = 1'b0;
      abs_running = '0;
      peak_running = 0;
      count_running = '0;
      return '0;
    end
    x = longint'(smp);
    scaled = x <<< cur_frac;
    // The first sample after a restart seeds the tracker with itself.
    if (!tracker_primed) begin
      tracker_level = scaled;
      tracker_primed = 1'b1;
    end
    tracker_level = tracker_level + ((scaled - tracker_level) >>> cur_rate);
    ac = (x - (tracker_level >>> cur_frac)) * longint'(cur_gain);
    if (ac > SAT_HI) begin
      ac = SAT_HI;
    end else if (ac < SAT_LO) begin
      ac = SAT_LO;
    end
    // Statistics track the magnitude, which reaches 2^(SW-1) on negative saturation.
    mag = (ac < 0) ? -ac : ac;
    abs_running = abs_running + mag[31:0];
    if (mag > peak_running) begin
      peak_running = mag;
    end
    count_running = count_running + 32'd1;
    beat.clean = ac[SW-1:0];
    beat.abs_sum = abs_running;
    beat.peak = peak_running[SW-1:0];
    beat.count = count_running;
    return beat;
  endfunction

  function automatic dir_row_t item_row(input logic req, input logic [SW-1:0] smp);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.req = req;
    r.smp = smp;
    r.frac = '0;
    r.rate = '0;
    r.gain = '0;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic req, input logic [SW-1:0] smp,
                                         input logic [SW-1:0] clean, input logic [31:0] abs_sum,
                                         input logic [SW-1:0] peak, input logic [31:0] count);
    dir_row_t r;
    r = item_row(req, smp);
    r.known = 1'b1;
    r.want.clean = clean;
    r.want.abs_sum = abs_sum;
    r.want.peak = peak;
    r.want.count = count;
    return r;
  endfunction

  function automatic dir_row_t regs_row(input logic [3:0] frac, input logic [3:0] rate,
                                        input logic [6:0] gain);
    dir_row_t r;
    r = item_row(REQ_SAMPLE, '0);
    r.kind = ROW_REGS;
    r.frac = frac;
    r.rate = rate;
    r.gain = gain;
    return r;
  endfunction

  // Sample source: mostly a DC offset plus noise, with corners and full-range values mixed in.
  function automatic logic [SW-1:0] pick_sample(input int center, input int spread);
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = int'(SAT_HI);
          1:       v = int'(SAT_LO);
          2:       v = 0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom);
      default: begin
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > SAT_HI) begin
          v = int'(SAT_HI);
        end else if (v < SAT_LO) begin
          v = int'(SAT_LO);
        end
      end
    endcase
    return v[SW-1:0];
  endfunction

  // Offer one beat, with an occasional gap in front of it. Valid stays high on return
  // so that back-to-back beats never lower and raise it within one step.
  task automatic send_item(input logic req, input logic [SW-1:0] smp, input bit known,
                           input clean_beat_t want);
    int gap;
    clean_beat_t beat;
    gap = (!calm && $urandom_range(0, 7) == 0) ? int'($urandom_range(1, 4)) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.sample <= smp;
    do @(posedge clk); while (!in_if.ready);
    beat = dc_block_step(req, smp);
    clean_queue.push_back(known ? want : beat);
    @(negedge clk);
  endtask

  // Stop offering beats and wait until every pending result has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (clean_queue.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_DC_FRAC_BITS:  cur_frac = data[3:0];
      CFG_DC_RATE_SHIFT: cur_rate = data[3:0];
      CFG_GAIN:          cur_gain = data[6:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic apply_regs(input logic [3:0] frac, input logic [3:0] rate,
                            input logic [6:0] gain);
    settle();
    write_reg(CFG_DC_FRAC_BITS, CFG_DATA_W'(frac));
    write_reg(CFG_DC_RATE_SHIFT, CFG_DATA_W'(rate));
    write_reg(CFG_GAIN, gain);
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: short random stalls, plus one long hold-off to back the pipeline up.
  initial begin
    int stall_left;
    int hold_left;
    bit held;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_seen >= HOLD_AT_BEAT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = int'($urandom_range(0, 3));
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest pending expectation.
  always @(posedge clk) begin
    clean_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      beats_seen++;
      if (clean_queue.size() == 0) begin
        mismatch_count++;
        $error("result beat arrived with no sample pending");
      end else begin
        want = clean_queue.pop_front();
        if (out_if.clean_sample !== want.clean) begin
          mismatch_count++;
          $error("clean_sample: expected %0d, got %0d", want.clean, out_if.clean_sample);
        end
        if (out_if.abs_sum !== want.abs_sum) begin
          mismatch_count++;
          $error("abs_sum: expected %0d, got %0d", want.abs_sum, out_if.abs_sum);
        end
        if (out_if.peak_level !== want.peak) begin
          mismatch_count++;
          $error("peak_level: expected %0d, got %0d", want.peak, out_if.peak_level);
        end
        if (out_if.sample_count !== want.count) begin
          mismatch_count++;
          $error("sample_count: expected %0d, got %0d", want.count, out_if.sample_count);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int center;
    int spread;
    logic [3:0] f;
    logic [3:0] r;
    logic [6:0] g;

    in_if.valid = 1'b0;
    in_if.req_type = REQ_SAMPLE;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DC_FRAC_BITS;
    cfg_if.data = '0;

    // Directed table. The first sample after reset or a restart always primes to zero,
    // and a restart always returns all zeros.
    directed.push_back(known_row(REQ_SAMPLE, 16'h0000, 16'h0000, 32'd0, 16'd0, 32'd1));
    directed.push_back(known_row(REQ_RESTART, 16'h7fff, 16'h0000, 32'd0, 16'd0, 32'd0));
    directed.push_back(known_row(REQ_SAMPLE, 16'h7fff, 16'h0000, 32'd0, 16'd0, 32'd1));
    // A full-scale swing saturates low, and the peak holds the unsigned magnitude.
    directed.push_back(known_row(REQ_SAMPLE, 16'h8000, 16'h8000, 32'd32768, 16'h8000, 32'd2));
    directed.push_back(item_row(REQ_SAMPLE, 16'h7fff));
    directed.push_back(item_row(REQ_SAMPLE, 16'hffff));
    directed.push_back(known_row(REQ_RESTART, 16'h8000, 16'h0000, 32'd0, 16'd0, 32'd0));
    // Rate shift of zero makes the tracker follow the input, so the output stays zero.
    directed.push_back(regs_row(4'd8, 4'd0, 7'd8));
    directed.push_back(known_row(REQ_SAMPLE, 16'h04d2, 16'h0000, 32'd0, 16'd0, 32'd1));
    directed.push_back(known_row(REQ_SAMPLE, 16'h8000, 16'h0000, 32'd0, 16'd0, 32'd2));
    directed.push_back(known_row(REQ_SAMPLE, 16'h7fff, 16'h0000, 32'd0, 16'd0, 32'd3));
    // Widest fraction, slowest tracker and the largest gain the register holds.
    directed.push_back(regs_row(4'd15, 4'd15, 7'd127));
    directed.push_back(known_row(REQ_RESTART, 16'h5a5a, 16'h0000, 32'd0, 16'd0, 32'd0));
    directed.push_back(known_row(REQ_SAMPLE, 16'h8000, 16'h0000, 32'd0, 16'd0, 32'd1));
    directed.push_back(item_row(REQ_SAMPLE, 16'h7fff));
    directed.push_back(item_row(REQ_SAMPLE, 16'h0000));
    // Zero gain and zero fraction bits, carried over a live tracker.
    directed.push_back(regs_row(4'd0, 4'd1, 7'd0));
    directed.push_back(item_row(REQ_SAMPLE, 16'd100));
    directed.push_back(item_row(REQ_SAMPLE, 16'h8000));
    directed.push_back(regs_row(4'd0, 4'd1, 7'd64));
    directed.push_back(known_row(REQ_RESTART, 16'h0000, 16'h0000, 32'd0, 16'd0, 32'd0));
    directed.push_back(known_row(REQ_SAMPLE, 16'h5555, 16'h0000, 32'd0, 16'd0, 32'd1));
    directed.push_back(item_row(REQ_SAMPLE, 16'haaaa));
    directed.push_back(item_row(REQ_SAMPLE, 16'h0001));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REGS) begin
        apply_regs(directed[i].frac, directed[i].rate, directed[i].gain);
      end else begin
        send_item(directed[i].req, directed[i].smp, directed[i].known, directed[i].want);
      end
    end

    // Random phases: each picks a register setting, a DC offset and a noise spread.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          f = 4'd15;
          r = 4'd1;
          g = 7'd64;
        end
        1: begin
          f = 4'd0;
          r = 4'd15;
          g = 7'd127;
        end
        2: begin
          f = FRAC_BITS_RST;
          r = RATE_SHIFT_RST;
          g = GAIN_RST;
        end
        3: begin
          f = 4'd4;
          r = 4'd0;
          g = 7'd1;
        end
        default: begin
          f = 4'($urandom_range(0, 15));
          r = 4'($urandom_range(1, 15));
          g = 7'($urandom_range(1, 64));
          if ($urandom_range(0, 3) == 0) begin
            g = 7'($urandom_range(0, 127));
          end
        end
      endcase
      calm = (ph == RAND_PHASES - 1);
      apply_regs(f, r, g);
      if ($urandom_range(0, 1) == 0) begin
        send_item(REQ_RESTART, SW'($urandom), 1'b0, '0);
      end
      center = int'($urandom_range(0, 40000)) - 20000;
      spread = 1 << $urandom_range(0, 12);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) begin
          send_item(REQ_RESTART, SW'($urandom), 1'b0, '0);
        end else begin
          send_item(REQ_SAMPLE, pick_sample(center, spread), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
